// ----- rtl/core/epat_pkg.sv -----
package epat_pkg;

    localparam int unsigned PIXEL_COUNT_DEF = 65536;
    localparam int unsigned CFG_IDX_W       = 2;

    localparam logic [15:0] GAIN_ONE = 16'd16384;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RELAX_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UP_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_GAIN  = 2'd2;

    // Item operations.
    localparam logic OP_PROCESS = 1'b0;
    localparam logic OP_LOAD    = 1'b1;

    // Event codes.
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_ABOVE = 2'd1;
    localparam logic [1:0] EV_BELOW = 2'd2;

    typedef struct packed {
        logic               op;
        logic [15:0]        pixel_index;
        logic signed [15:0] pixel_value;
        logic signed [15:0] load_reference;
        logic [15:0]        load_threshold;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         event_code;
        logic signed [15:0] gated_difference;
        logic [15:0]        new_threshold;
    } t_out_item;

endpackage

// ----- rtl/core/event_pixel_adaptive_threshold_top.sv -----
// Event-camera pixel emulator with a per-pixel reference level and adaptive threshold.
// Input channel: i_in_valid / o_in_stall carry one pixel transaction (process or load).
// Output channel: o_out_valid / i_out_stall carry exactly one result per input transaction,
// in the order the inputs were accepted.
// Configuration channel: i_cfg_valid / o_cfg_ready write relax_gain, up_gain and down_gain;
// it is always ready, and writes are expected only while no transaction is in flight.
// Path: an accepted input goes through the memory read, the multiply, and the update and
// write back, and its result is held in an output register.
// Throughput: one transaction per cycle unless an output stall or a pixel hazard holds it.
// The per-pixel read-modify-write loop runs through the multiplier stage, so an input whose
// pixel is in one of the three stages before the output register waits for that write back.
// Stalls are per stage: an empty stage fills even while the output is stalled, and the
// output register holds its result until the receiver takes it.
// Reset clears all valid bits and sets the three gains to 1.0. The pixel stores are not
// cleared; a pixel must be loaded before it is processed.
module event_pixel_adaptive_threshold_top #(
    parameter int unsigned PIXEL_COUNT = epat_pkg::PIXEL_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  epat_pkg::t_in_item                i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output epat_pkg::t_out_item               o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [epat_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [15:0]                       i_cfg_data
);
    import epat_pkg::*;

    localparam int unsigned ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

    // Configuration registers.
    logic [15:0] r_relax_gain;
    logic [15:0] r_up_gain;
    logic [15:0] r_down_gain;

    // Pixel stores.
    logic signed [15:0] r_ref_mem [PIXEL_COUNT];
    logic [15:0]        r_thr_mem [PIXEL_COUNT];

    // Stage valid bits.
    logic r_s1_v, r_s2_v, r_s3_v, r_out_v;

    // Stage 1: item and stored entry.
    logic               r_s1_op;
    logic               r_s1_inr;
    logic [ADDR_W-1:0]  r_s1_addr;
    logic signed [15:0] r_s1_pix;
    logic signed [15:0] r_s1_lref;
    logic [15:0]        r_s1_lthr;
    logic signed [15:0] r_s1_ref;
    logic [15:0]        r_s1_thr;

    // Stage 2: gated difference and operands of the two products.
    logic               r_s2_op;
    logic               r_s2_inr;
    logic [ADDR_W-1:0]  r_s2_addr;
    logic signed [15:0] r_s2_lref;
    logic [15:0]        r_s2_lthr;
    logic signed [15:0] r_s2_ref;
    logic [15:0]        r_s2_thr;
    logic [15:0]        r_s2_gain;
    logic signed [16:0] r_s2_gated;

    // Stage 3: products.
    logic               r_s3_op;
    logic               r_s3_inr;
    logic [ADDR_W-1:0]  r_s3_addr;
    logic signed [15:0] r_s3_lref;
    logic [15:0]        r_s3_lthr;
    logic signed [16:0] r_s3_gated;
    logic signed [32:0] r_s3_pref;
    logic [31:0]        r_s3_pthr;

    t_out_item r_out;

    // Stage enables: a stage loads when it is empty or the stage after it loads.
    logic en_out, en_s3, en_s2, en_s1;
    logic in_inr, hazard, in_accept;
    logic [ADDR_W-1:0] in_addr;

    assign en_out = !r_out_v || !i_out_stall;
    assign en_s3  = !r_s3_v || en_out;
    assign en_s2  = !r_s2_v || en_s3;
    assign en_s1  = !r_s1_v || en_s2;

    assign in_inr  = 32'(i_in.pixel_index) < 32'(PIXEL_COUNT);
    assign in_addr = ADDR_W'(i_in.pixel_index);

    // A transaction may not read a pixel that an earlier one has yet to write back.
    assign hazard = in_inr && (
        (r_s1_v && r_s1_inr && r_s1_addr == in_addr) ||
        (r_s2_v && r_s2_inr && r_s2_addr == in_addr) ||
        (r_s3_v && r_s3_inr && r_s3_addr == in_addr));

    assign o_in_stall = !en_s1 || hazard;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Stage 1 logic: difference, threshold gate, gain select.
    logic signed [16:0] s1_diff;
    logic signed [17:0] s1_diff18;
    logic signed [17:0] s1_thr18;
    logic               s1_fire;

    assign s1_diff   = {r_s1_pix[15], r_s1_pix} - {r_s1_ref[15], r_s1_ref};
    assign s1_diff18 = {s1_diff[16], s1_diff};
    assign s1_thr18  = {2'b00, r_s1_thr};
    assign s1_fire   = (s1_diff18 > s1_thr18) || (s1_diff18 < -s1_thr18);

    // Stage 3 logic: scale down, add, saturate, classify.
    logic signed [18:0] s3_floor;
    logic signed [19:0] s3_nref_full;
    logic signed [15:0] s3_nref;
    logic [17:0]        s3_nthr_full;
    logic [15:0]        s3_nthr;
    logic signed [17:0] s3_gated18;
    logic signed [17:0] s3_nthr18;
    logic [1:0]         s3_code;
    logic signed [15:0] s3_gated_sat;
    logic               mem_we;
    logic signed [15:0] wr_ref;
    logic [15:0]        wr_thr;
    t_out_item          n_out;

    always_comb begin
        // Dropping the low 14 bits of a two's complement product floors it.
        s3_floor     = r_s3_pref[32:14];
        s3_nref_full = {s3_floor[18], s3_floor} + {{3{r_s3_gated[16]}}, r_s3_gated};
        if (s3_nref_full > 20'sd32767) begin
            s3_nref = 16'sh7FFF;
        end else if (s3_nref_full < -20'sd32768) begin
            s3_nref = -16'sd32768;
        end else begin
            s3_nref = s3_nref_full[15:0];
        end

        s3_nthr_full = r_s3_pthr[31:14];
        s3_nthr      = (s3_nthr_full[17:16] != 2'b00) ? 16'hFFFF : s3_nthr_full[15:0];

        s3_gated18 = {r_s3_gated[16], r_s3_gated};
        s3_nthr18  = {2'b00, s3_nthr};
        if (s3_gated18 > s3_nthr18) begin
            s3_code = EV_ABOVE;
        end else if (s3_gated18 < -s3_nthr18) begin
            s3_code = EV_BELOW;
        end else begin
            s3_code = EV_NONE;
        end

        if (r_s3_gated > 17'sd32767) begin
            s3_gated_sat = 16'sh7FFF;
        end else if (r_s3_gated < -17'sd32768) begin
            s3_gated_sat = -16'sd32768;
        end else begin
            s3_gated_sat = r_s3_gated[15:0];
        end

        n_out  = '0;
        wr_ref = s3_nref;
        wr_thr = s3_nthr;
        if (r_s3_inr) begin
            if (r_s3_op == OP_LOAD) begin
                wr_ref              = r_s3_lref;
                wr_thr              = r_s3_lthr;
                n_out.new_threshold = r_s3_lthr;
            end else begin
                n_out.event_code       = s3_code;
                n_out.gated_difference = s3_gated_sat;
                n_out.new_threshold    = s3_nthr;
            end
        end
    end

    assign mem_we = r_s3_v && en_out && r_s3_inr;

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v       <= 1'b0;
            r_s2_v       <= 1'b0;
            r_s3_v       <= 1'b0;
            r_out_v      <= 1'b0;
            r_relax_gain <= GAIN_ONE;
            r_up_gain    <= GAIN_ONE;
            r_down_gain  <= GAIN_ONE;
        end else begin
            if (en_s1) begin
                r_s1_v <= in_accept;
            end
            if (en_s2) begin
                r_s2_v <= r_s1_v;
            end
            if (en_s3) begin
                r_s3_v <= r_s2_v;
            end
            if (en_out) begin
                r_out_v <= r_s3_v;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_RELAX_GAIN: r_relax_gain <= i_cfg_data;
                    REG_UP_GAIN:    r_up_gain    <= i_cfg_data;
                    REG_DOWN_GAIN:  r_down_gain  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Pixel store read port; the read data is part of stage 1.
    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r_s1_ref <= r_ref_mem[in_addr];
            r_s1_thr <= r_thr_mem[in_addr];
        end
    end

    // Pixel store write port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ref_mem[r_s3_addr] <= wr_ref;
            r_thr_mem[r_s3_addr] <= wr_thr;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r_s1_op   <= i_in.op;
            r_s1_inr  <= in_inr;
            r_s1_addr <= in_addr;
            r_s1_pix  <= i_in.pixel_value;
            r_s1_lref <= i_in.load_reference;
            r_s1_lthr <= i_in.load_threshold;
        end
        if (en_s2) begin
            r_s2_op    <= r_s1_op;
            r_s2_inr   <= r_s1_inr;
            r_s2_addr  <= r_s1_addr;
            r_s2_lref  <= r_s1_lref;
            r_s2_lthr  <= r_s1_lthr;
            r_s2_ref   <= r_s1_ref;
            r_s2_thr   <= r_s1_thr;
            r_s2_gain  <= s1_fire ? r_up_gain : r_down_gain;
            r_s2_gated <= s1_fire ? s1_diff : 17'sd0;
        end
        if (en_s3) begin
            r_s3_op    <= r_s2_op;
            r_s3_inr   <= r_s2_inr;
            r_s3_addr  <= r_s2_addr;
            r_s3_lref  <= r_s2_lref;
            r_s3_lthr  <= r_s2_lthr;
            r_s3_gated <= r_s2_gated;
            r_s3_pref  <= $signed({1'b0, r_relax_gain}) * r_s2_ref;
            r_s3_pthr  <= r_s2_thr * r_s2_gain;
        end
        if (en_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    // A write back always produces a result in the output register.
    a_write_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> r_out_v)
        else $error("pixel store written without a result");

    // A load reports no event and no difference.
    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_s3_op == OP_LOAD) |=>
            (o_out.event_code == EV_NONE && o_out.gated_difference == 16'sd0))
        else $error("load transaction reported an event");

    // No accepted transaction reads a pixel still being updated further down.
    a_no_raw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && in_inr && r_s3_v && r_s3_inr) |-> (r_s3_addr != in_addr))
        else $error("read of a pixel with a pending write back");

    // The output never carries the unused event code.
    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.event_code[1] && o_out.event_code[0]))
        else $error("invalid event code");

endmodule
